// File: rtl/core/iasu_pkg.sv
// Package: shared codes, state encoding and controller/datapath interface types.
package iasu_pkg;

   localparam int unsigned CMD_W    = 2;
   localparam int unsigned POS_W    = 7;
   localparam int unsigned WORD_W   = 32;
   localparam int unsigned LEN_W    = 7;
   localparam int unsigned STATUS_W = 2;

   typedef enum logic [CMD_W-1:0] {
      OP_APPEND = 2'd0,
      OP_INSERT = 2'd1,
      OP_WRITE  = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_PLACE,
      S_RESPOND
   } state_type;

   typedef struct packed {
      logic accept;
      logic check;
      logic shift_rd;
      logic shift_wr;
      logic place;
      logic fill_inc;
   } dp_ctl_type;

   typedef struct packed {
      op_type     op;
      status_type chk_status;
      logic       shift_needed;
      logic       shift_last;
   } dp_stat_type;

endpackage

// File: rtl/core/iasu_ctrl.sv
// Controller: sequences check, shift sweep, placement and response of one item.
module iasu_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output logic                 rsp_valid,
   output iasu_pkg::dp_ctl_type ctl,
   input  iasu_pkg::dp_stat_type stat
);
   import iasu_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (stat.chk_status != ST_DONE) begin
               state_in = S_RESPOND;
            end else begin
               unique case (stat.op)
                  OP_READ:  state_in = S_RESPOND;
                  OP_WRITE: state_in = S_PLACE;
                  default:  state_in = stat.shift_needed ? S_SHIFT_RD : S_PLACE;
               endcase
            end
         end
         S_SHIFT_RD: state_in = S_SHIFT_WR;
         S_SHIFT_WR: state_in = stat.shift_last ? S_PLACE : S_SHIFT_RD;
         S_PLACE:    state_in = S_RESPOND;
         S_RESPOND:  state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_comb begin
      ctl       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            busy       = 1'b0;
            ctl.accept = start;
         end
         S_CHECK:    ctl.check = 1'b1;
         S_SHIFT_RD: ctl.shift_rd = 1'b1;
         S_SHIFT_WR: ctl.shift_wr = 1'b1;
         S_PLACE: begin
            ctl.place    = 1'b1;
            ctl.fill_inc = (stat.op == OP_APPEND) || (stat.op == OP_INSERT);
         end
         S_RESPOND:  rsp_valid = 1'b1;
         default:    busy = 1'b1;
      endcase
   end

endmodule

// File: rtl/core/iasu_datapath.sv
// Datapath: entry memory, fill count, item registers, range checks and result fields.
module iasu_datapath #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  iasu_pkg::dp_ctl_type                 ctl,
   output iasu_pkg::dp_stat_type                stat,
   input  logic [iasu_pkg::CMD_W-1:0]           req_command,
   input  logic [iasu_pkg::POS_W-1:0]           req_position,
   input  logic signed [iasu_pkg::WORD_W-1:0]   req_value,
   output logic signed [iasu_pkg::WORD_W-1:0]   rsp_read_value,
   output logic [iasu_pkg::LEN_W-1:0]           rsp_length,
   output logic [iasu_pkg::STATUS_W-1:0]        rsp_status
);
   import iasu_pkg::*;

   localparam int unsigned AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CW   = $clog2(CAPACITY + 1);
   localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;

   logic signed [WORD_W-1:0] mem [CAPACITY];

   logic [CW-1:0]            fill_ff;
   logic [CW-1:0]            fill_in;
   op_type                   op_ff;
   logic [CMPW-1:0]          pos_ff;
   logic signed [WORD_W-1:0] value_ff;
   logic [AW-1:0]            idx_ff;
   logic [AW-1:0]            idx_in;
   status_type               status_ff;
   logic signed [WORD_W-1:0] rdata_ff;

   logic [CMPW-1:0] fill_w;
   logic [AW-1:0]   pos_addr;
   logic [AW-1:0]   rd_addr;
   logic            rd_en;
   logic            is_ins;
   status_type      chk_status;

   assign fill_w   = CMPW'(fill_ff);
   assign pos_addr = pos_ff[AW-1:0];
   assign is_ins   = (op_ff == OP_APPEND) || (op_ff == OP_INSERT);

   always_comb begin
      chk_status = ST_DONE;
      if (is_ins) begin
         if (pos_ff > fill_w) begin
            chk_status = ST_RANGE;
         end else if (fill_ff == CW'(CAPACITY)) begin
            chk_status = ST_FULL;
         end
      end else if (pos_ff >= fill_w) begin
         chk_status = ST_RANGE;
      end
   end

   assign stat.op           = op_ff;
   assign stat.chk_status   = chk_status;
   assign stat.shift_needed = (pos_ff != fill_w);
   assign stat.shift_last   = (idx_ff == pos_addr);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   assign fill_in = ctl.fill_inc ? CW'(fill_ff + CW'(1)) : fill_ff;

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         op_ff    <= op_type'(req_command);
         pos_ff   <= (op_type'(req_command) == OP_APPEND) ? fill_w : CMPW'(req_position);
         value_ff <= req_value;
      end
      if (ctl.check) begin
         status_ff <= chk_status;
      end
      idx_ff <= idx_in;
   end

   always_comb begin
      idx_in = idx_ff;
      if (ctl.check) begin
         idx_in = AW'(fill_ff - CW'(1));
      end else if (ctl.shift_wr) begin
         idx_in = AW'(idx_ff - AW'(1));
      end
   end

   assign rd_en   = ctl.check || ctl.shift_rd;
   assign rd_addr = ctl.check ? pos_addr : idx_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.shift_wr) begin
         mem[AW'(idx_ff + AW'(1))] <= rdata_ff;
      end else if (ctl.place) begin
         mem[pos_addr] <= value_ff;
      end
   end

   assign rsp_read_value = ((op_ff == OP_READ) && (status_ff == ST_DONE)) ? rdata_ff : '0;
   assign rsp_length     = fill_w[LEN_W-1:0];
   assign rsp_status     = status_ff;

endmodule

// File: rtl/core/insertable_array_store_unit.sv
// Top level: ordered word store with append, insert, overwrite and read commands.
//
//  channel   | handshake            | fields
//  ----------+----------------------+------------------------------------------
//  request   | start in, busy out   | req_command, req_position, req_value
//  response  | rsp_valid out        | rsp_read_value, rsp_length, rsp_status
//
// An item is taken when start is high and busy is low; busy stays high until
// its result has been shown. Reads and refused commands go from the check straight
// to the response, overwrites and appends at the end place the word first; an
// insert at position p with n entries stored first moves n-p entries up, one read
// and one write per moved entry. Reset (synchronous) empties the store. rsp_valid
// is high for one cycle and the receiver cannot stall it.
module insertable_array_store_unit #(
   parameter int unsigned CAPACITY = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [iasu_pkg::CMD_W-1:0]         req_command,
   input  logic [iasu_pkg::POS_W-1:0]         req_position,
   input  logic signed [iasu_pkg::WORD_W-1:0] req_value,
   output logic                               rsp_valid,
   output logic signed [iasu_pkg::WORD_W-1:0] rsp_read_value,
   output logic [iasu_pkg::LEN_W-1:0]         rsp_length,
   output logic [iasu_pkg::STATUS_W-1:0]      rsp_status
);
   import iasu_pkg::*;

   dp_ctl_type  ctl;
   dp_stat_type stat;

   iasu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .ctl       (ctl),
      .stat      (stat)
   );

   iasu_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .stat           (stat),
      .req_command    (req_command),
      .req_position   (req_position),
      .req_value      (req_value),
      .rsp_read_value (rsp_read_value),
      .rsp_length     (rsp_length),
      .rsp_status     (rsp_status)
   );

endmodule
